// ===== design/s2x_pkg.sv =====
// ----------------------------------------------------------------------------
// s2x_pkg: shared types, constants and functions of the Scale2x upscaler
// Holds pixel and coordinate widths, the register map, the result-slot
// codes and the Scale2x kernel used by the output blocks.
// ----------------------------------------------------------------------------
package s2x_pkg;

   // Field widths
   localparam int PIX_W     = 32;
   localparam int COORD_W   = 8;
   localparam int SIZE_W    = 9;
   localparam int CSR_IDX_W = 1;

   // Frame limits and reset sizes
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(160);
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(144);

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Result slots of one item, in delivery order
   localparam int NUM_SLOTS = 3;
   localparam logic [1:0] SLOT_ABOVE = 2'd0;   // center one row up
   localparam logic [1:0] SLOT_LEFT  = 2'd1;   // last-row center one column left
   localparam logic [1:0] SLOT_SELF  = 2'd2;   // final pixel of the frame

   typedef struct packed {
      logic [PIX_W-1:0] top_left;
      logic [PIX_W-1:0] top_right;
      logic [PIX_W-1:0] bottom_left;
      logic [PIX_W-1:0] bottom_right;
   } quad_type;

   typedef struct packed {
      quad_type           pix;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } blk_type;

   // Results of one item handed to the output queue
   typedef struct packed {
      logic [NUM_SLOTS-1:0]          mask;
      blk_type [NUM_SLOTS-1:0]       blk;
   } load_type;

   // Scale2x rule on center e with neighbors b (up), d (left), f (right), h (down)
   function automatic quad_type scale2x(input logic [PIX_W-1:0] e,
                                        input logic [PIX_W-1:0] b,
                                        input logic [PIX_W-1:0] d,
                                        input logic [PIX_W-1:0] f,
                                        input logic [PIX_W-1:0] h);
      quad_type q;
      q.top_left     = e;
      q.top_right    = e;
      q.bottom_left  = e;
      q.bottom_right = e;
      if ((b != h) && (d != f)) begin
         q.top_left     = (d == b) ? d : e;
         q.top_right    = (b == f) ? f : e;
         q.bottom_left  = (d == h) ? d : e;
         q.bottom_right = (h == f) ? f : e;
      end
      return q;
   endfunction

   // Last valid index for a size register, size clamped to 2..max_size
   function automatic logic [COORD_W-1:0] last_index(input logic [SIZE_W-1:0] size,
                                                     input logic [SIZE_W-1:0] max_size);
      logic [SIZE_W-1:0] lim;
      if (size < SIZE_W'(2)) begin
         lim = SIZE_W'(2);
      end else if (size > max_size) begin
         lim = max_size;
      end else begin
         lim = size;
      end
      lim = lim - SIZE_W'(1);
      return lim[COORD_W-1:0];
   endfunction

endpackage

// ===== design/s2x_ram.sv =====
// ----------------------------------------------------------------------------
// s2x_ram: generic line store
// One write port, two registered read ports sharing a read enable.
// A read of the entry written at the same edge returns the old data.
// ----------------------------------------------------------------------------
module s2x_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== design/s2x_emit.sv =====
// ----------------------------------------------------------------------------
// s2x_emit: output queue of the Scale2x upscaler
// Holds the up to three result blocks of one item and hands them out one
// per cycle in slot order while rsp_stall is low, marking the final one of the item.
// ----------------------------------------------------------------------------
module s2x_emit
   import s2x_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load_en,
   input  load_type           load,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PIX_W-1:0]   rsp_top_left,
   output logic [PIX_W-1:0]   rsp_top_right,
   output logic [PIX_W-1:0]   rsp_bottom_left,
   output logic [PIX_W-1:0]   rsp_bottom_right,
   output logic [COORD_W-1:0] rsp_center_col,
   output logic [COORD_W-1:0] rsp_center_row,
   output logic               rsp_frame_end,
   output logic               rsp_last
);

   logic [NUM_SLOTS-1:0] mask_ff;
   logic [NUM_SLOTS-1:0] mask_in;
   blk_type [NUM_SLOTS-1:0] blk_ff;
   logic [NUM_SLOTS-1:0] sel_oh;
   logic [NUM_SLOTS-1:0] rest;
   logic [1:0]           sel_idx;
   logic                 take;
   blk_type              cur;

   // Lowest pending slot goes first
   assign sel_oh  = mask_ff & (~mask_ff + NUM_SLOTS'(1));
   assign rest    = mask_ff & ~sel_oh;
   assign sel_idx = mask_ff[SLOT_ABOVE] ? SLOT_ABOVE :
                    mask_ff[SLOT_LEFT]  ? SLOT_LEFT  : SLOT_SELF;

   always_comb begin
      case (sel_idx)
         SLOT_ABOVE: cur = blk_ff[SLOT_ABOVE];
         SLOT_LEFT:  cur = blk_ff[SLOT_LEFT];
         default:    cur = blk_ff[SLOT_SELF];
      endcase
   end

   assign rsp_valid        = |mask_ff;
   assign take             = rsp_valid && !rsp_stall;
   assign free             = !rsp_valid || (take && (rest == '0));
   assign rsp_top_left     = cur.pix.top_left;
   assign rsp_top_right    = cur.pix.top_right;
   assign rsp_bottom_left  = cur.pix.bottom_left;
   assign rsp_bottom_right = cur.pix.bottom_right;
   assign rsp_center_col   = cur.col;
   assign rsp_center_row   = cur.row;
   assign rsp_frame_end    = sel_oh[SLOT_SELF];
   assign rsp_last         = (rest == '0);

   // Pending slot mask
   always_comb begin
      mask_in = mask_ff;
      if (load_en) begin
         mask_in = load.mask;
      end else if (take) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // Block payload
   always_ff @(posedge clock) begin
      if (load_en) begin
         blk_ff <= load.blk;
      end
   end

   // A new item is only loaded when the queue is empty or drains this cycle
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_en |-> free)
      else $error("output queue loaded while results pending");

   // The item's final result leaves the queue empty unless a new item loads
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (take && rsp_last && !load_en) |=> !rsp_valid)
      else $error("results remain after last");

   // Frame end only on the item's final result
   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_last)
      else $error("frame end not on last result");

endmodule

// ===== design/scale2x_pixel_upscaler.sv =====
// ----------------------------------------------------------------------------
// scale2x_pixel_upscaler: streaming Scale2x 2x pixel upscaler
// Path: an accepted item is registered in the read stage, then its results are
// loaded into the output queue, which offers them; the read stage waits while the queue is busy.
// Throughput: one item per cycle while each item gives at most one result and
// rsp_stall is low; extra results (up to three in all on the last row) hold input until taken.
// Reset: counters and window cleared, sizes 160 x 144; line stores keep
// their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module scale2x_pixel_upscaler
   import s2x_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_top_left,
   output logic [PIX_W-1:0]     rsp_top_right,
   output logic [PIX_W-1:0]     rsp_bottom_left,
   output logic [PIX_W-1:0]     rsp_bottom_right,
   output logic [COORD_W-1:0]   rsp_center_col,
   output logic [COORD_W-1:0]   rsp_center_row,
   output logic                 rsp_frame_end,
   output logic                 rsp_last,
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   // Size registers
   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [COORD_W-1:0] wm1, hm1;

   // Position and row window
   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [PIX_W-1:0]   prev1_ff, prev1_in, prev2_ff, prev2_in;
   logic [COORD_W-1:0] cur_col, cur_row;
   logic               cur_last_col, cur_last_row;
   logic               accept;

   // Read stage
   logic               s1_valid_ff;
   logic [PIX_W-1:0]   s1_pix_ff, s1_prev1_ff, s1_prev2_ff;
   logic [COORD_W-1:0] s1_col_ff, s1_row_ff;
   logic               s1_last_col_ff, s1_last_row_ff;
   logic               s1_adv;
   logic               q_free;

   // Last write, forwarded into the read that shares its edge
   logic               fwd_valid_ff;
   logic [COORD_W-1:0] fwd_addr_ff;
   logic [PIX_W-1:0]   fwd_older_ff, fwd_recent_ff;

   // Line store data
   logic [PIX_W-1:0]   older_rd_a, older_rd_b, recent_rd_a, recent_rd_b;
   logic [PIX_W-1:0]   older_c, older_cm1, recent_c, recent_cp1;
   logic [COORD_W-1:0] s1_cm1, s1_cp1;
   logic [PIX_W-1:0]   b0, d0, f0, d1, d2;
   load_type           load;

   // Configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign wm1 = last_index(width_ff, SIZE_W'(MAX_WIDTH));
   assign hm1 = last_index(height_ff, SIZE_W'(MAX_HEIGHT));

   // Position of the next item, held inside the frame
   assign cur_col      = (col_ff > wm1) ? wm1 : col_ff;
   assign cur_row      = (row_ff > hm1) ? hm1 : row_ff;
   assign cur_last_col = (cur_col == wm1);
   assign cur_last_row = (cur_row == hm1);

   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign s1_adv    = s1_valid_ff && q_free;

   // Counter and window update per item
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      prev1_in = prev1_ff;
      prev2_in = prev2_ff;
      if (accept) begin
         if (cur_last_col) begin
            col_in   = '0;
            row_in   = cur_last_row ? '0 : cur_row + COORD_W'(1);
            prev1_in = '0;
            prev2_in = '0;
         end else begin
            col_in   = cur_col + COORD_W'(1);
            row_in   = cur_row;
            prev1_in = req_pixel;
            prev2_in = prev1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         prev1_ff <= '0;
         prev2_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         prev1_ff <= prev1_in;
         prev2_ff <= prev2_in;
      end
   end

   // Read stage: item waits here for line store data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= req_pixel;
         s1_col_ff      <= cur_col;
         s1_row_ff      <= cur_row;
         s1_last_col_ff <= cur_last_col;
         s1_last_row_ff <= cur_last_row;
         s1_prev1_ff    <= prev1_ff;
         s1_prev2_ff    <= prev2_ff;
      end
   end

   // Line stores: older holds row r-2, recent holds row r-1 ahead of the column
   s2x_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
      .clock     (clock),
      .wr_en     (s1_adv),
      .wr_addr   (s1_col_ff),
      .wr_data   (recent_c),
      .rd_en     (accept),
      .rd_addr_a (cur_col),
      .rd_addr_b (cur_col - COORD_W'(1)),
      .rd_data_a (older_rd_a),
      .rd_data_b (older_rd_b)
   );

   s2x_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_recent (
      .clock     (clock),
      .wr_en     (s1_adv),
      .wr_addr   (s1_col_ff),
      .wr_data   (s1_pix_ff),
      .rd_en     (accept),
      .rd_addr_a (cur_col),
      .rd_addr_b (cur_col + COORD_W'(1)),
      .rd_data_a (recent_rd_a),
      .rd_data_b (recent_rd_b)
   );

   // Forwarding register of the last write
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         fwd_addr_ff   <= s1_col_ff;
         fwd_older_ff  <= recent_c;
         fwd_recent_ff <= s1_pix_ff;
      end
   end

   assign s1_cm1 = s1_col_ff - COORD_W'(1);
   assign s1_cp1 = s1_col_ff + COORD_W'(1);

   assign older_c    = (fwd_valid_ff && fwd_addr_ff == s1_col_ff) ? fwd_older_ff  : older_rd_a;
   assign older_cm1  = (fwd_valid_ff && fwd_addr_ff == s1_cm1)    ? fwd_older_ff  : older_rd_b;
   assign recent_c   = (fwd_valid_ff && fwd_addr_ff == s1_col_ff) ? fwd_recent_ff : recent_rd_a;
   assign recent_cp1 = (fwd_valid_ff && fwd_addr_ff == s1_cp1)    ? fwd_recent_ff : recent_rd_b;

   // Neighbors with frame-edge substitution
   assign b0 = (s1_row_ff == COORD_W'(1)) ? recent_c : older_c;
   assign d0 = (s1_col_ff == '0) ? recent_c : older_cm1;
   assign f0 = s1_last_col_ff ? recent_c : recent_cp1;
   assign d1 = (s1_col_ff == COORD_W'(1)) ? s1_prev1_ff : s1_prev2_ff;
   assign d2 = (s1_col_ff == '0) ? s1_pix_ff : s1_prev1_ff;

   // Result blocks of the item
   always_comb begin
      load.mask[SLOT_ABOVE] = (s1_row_ff != '0);
      load.mask[SLOT_LEFT]  = s1_last_row_ff && (s1_col_ff != '0);
      load.mask[SLOT_SELF]  = s1_last_row_ff && s1_last_col_ff;

      load.blk[SLOT_ABOVE].pix = scale2x(recent_c, b0, d0, f0, s1_pix_ff);
      load.blk[SLOT_ABOVE].col = s1_col_ff;
      load.blk[SLOT_ABOVE].row = s1_row_ff - COORD_W'(1);

      load.blk[SLOT_LEFT].pix  = scale2x(s1_prev1_ff, older_cm1, d1, s1_pix_ff, s1_prev1_ff);
      load.blk[SLOT_LEFT].col  = s1_cm1;
      load.blk[SLOT_LEFT].row  = s1_row_ff;

      load.blk[SLOT_SELF].pix  = scale2x(s1_pix_ff, recent_c, d2, s1_pix_ff, s1_pix_ff);
      load.blk[SLOT_SELF].col  = s1_col_ff;
      load.blk[SLOT_SELF].row  = s1_row_ff;
   end

   // Output queue
   s2x_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .load_en          (s1_adv),
      .load             (load),
      .free             (q_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_top_left     (rsp_top_left),
      .rsp_top_right    (rsp_top_right),
      .rsp_bottom_left  (rsp_bottom_left),
      .rsp_bottom_right (rsp_bottom_right),
      .rsp_center_col   (rsp_center_col),
      .rsp_center_row   (rsp_center_row),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_last         (rsp_last)
   );

   // Accepted item occupies the read stage next cycle
   a_accept_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost before read stage");

   // Column counter stays inside the row after an item
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> (col_ff <= $past(wm1)))
      else $error("column counter beyond row");

   // Forwarding register tracks every line store write
   a_fwd_track: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (fwd_valid_ff && fwd_addr_ff == $past(s1_col_ff)))
      else $error("forwarding register missed a write");

endmodule

// ===== tb/tb_scale2x_pixel_upscaler.sv =====
// ----------------------------------------------------------------------------
// tb_scale2x_pixel_upscaler: self-checking bench for the Scale2x upscaler
// Streams whole frames of pixels through the block and predicts every 2x2
// output block with an in-bench copy of the raster window. Covers clamped
// frame sizes, the Scale2x rule, size changes in mid-frame, random frames
// and the widest row, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_scale2x_pixel_upscaler
   import s2x_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Pixel values with distinct bit patterns
   localparam logic [PIX_W-1:0] PIX_ZERO = 32'h0000_0000;
   localparam logic [PIX_W-1:0] PIX_ONES = 32'hFFFF_FFFF;
   localparam logic [PIX_W-1:0] PIX_ODD  = 32'h5555_5555;
   localparam logic [PIX_W-1:0] PIX_EVEN = 32'hAAAA_AAAA;

   typedef struct packed {
      logic [PIX_W-1:0]   top_left;
      logic [PIX_W-1:0]   top_right;
      logic [PIX_W-1:0]   bottom_left;
      logic [PIX_W-1:0]   bottom_right;
      logic [COORD_W-1:0] center_col;
      logic [COORD_W-1:0] center_row;
      logic               frame_end;
      logic               last;
   } upscale_block_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   logic [PIX_W-1:0]     rsp_top_left;
   logic [PIX_W-1:0]     rsp_top_right;
   logic [PIX_W-1:0]     rsp_bottom_left;
   logic [PIX_W-1:0]     rsp_bottom_right;
   logic [COORD_W-1:0]   rsp_center_col;
   logic [COORD_W-1:0]   rsp_center_row;
   logic                 rsp_frame_end;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_wdata = '0;

   scale2x_pixel_upscaler dut (.*);

   // Predicted blocks, oldest first
   upscale_block_type blocks_due[$];
   int                mismatches = 0;

   // Idle modes: when set, that side never pauses
   bit src_steady  = 1'b0;
   bit sink_steady = 1'b0;

   // Shadow of the block's sizes, line buffers, row window and position
   logic [SIZE_W-1:0] cfg_width  = RESET_WIDTH;
   logic [SIZE_W-1:0] cfg_height = RESET_HEIGHT;
   logic [PIX_W-1:0]  older_line  [MAX_WIDTH];
   logic [PIX_W-1:0]  recent_line [MAX_WIDTH];
   logic [PIX_W-1:0]  prev_one = '0;
   logic [PIX_W-1:0]  prev_two = '0;
   int                col_pos = 0;
   int                row_pos = 0;

   initial begin : clock_gen
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      #6_000_000;
      $display("tb_scale2x_pixel_upscaler failed");
      $finish;
   end

   function automatic int pause_len(input bit steady);
      return steady ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic int clamp_dim(input logic [SIZE_W-1:0] size, input int limit);
      int s;
      s = int'(size);
      if (s < 2) return 2;
      if (s > limit) return limit;
      return s;
   endfunction

   // Scale2x on center e with up, left, right and down neighbors
   function automatic upscale_block_type make_block(input logic [PIX_W-1:0] e,
                                                    input logic [PIX_W-1:0] up,
                                                    input logic [PIX_W-1:0] lf,
                                                    input logic [PIX_W-1:0] rt,
                                                    input logic [PIX_W-1:0] dn,
                                                    input int col, input int row,
                                                    input bit fend);
      upscale_block_type blk;
      blk.top_left     = e;
      blk.top_right    = e;
      blk.bottom_left  = e;
      blk.bottom_right = e;
      if (up != dn && lf != rt) begin
         blk.top_left     = (lf == up) ? lf : e;
         blk.top_right    = (up == rt) ? rt : e;
         blk.bottom_left  = (lf == dn) ? lf : e;
         blk.bottom_right = (dn == rt) ? rt : e;
      end
      blk.center_col = col[COORD_W-1:0];
      blk.center_row = row[COORD_W-1:0];
      blk.frame_end  = fend;
      blk.last       = 1'b0;
      return blk;
   endfunction

   // Advance the raster window by one pixel and queue the blocks it completes
   function automatic void expand_pixel(input logic [PIX_W-1:0] p);
      int                w;
      int                ht;
      int                c;
      int                r;
      int                n;
      bit                at_right;
      bit                at_bottom;
      logic [PIX_W-1:0]  e;
      logic [PIX_W-1:0]  up;
      logic [PIX_W-1:0]  lf;
      logic [PIX_W-1:0]  rt;
      upscale_block_type found [3];
      w  = clamp_dim(cfg_width, MAX_WIDTH);
      ht = clamp_dim(cfg_height, MAX_HEIGHT);
      // a position beyond a shrunk size counts as the last column / row
      c  = (col_pos > w - 1) ? w - 1 : col_pos;
      r  = (row_pos > ht - 1) ? ht - 1 : row_pos;
      at_right  = (c == w - 1);
      at_bottom = (r == ht - 1);
      n = 0;
      // center one row up now has its lower neighbor
      if (r >= 1) begin
         e  = recent_line[c];
         up = (r == 1) ? e : older_line[c];
         lf = (c == 0) ? e : older_line[c - 1];
         rt = at_right ? e : recent_line[c + 1];
         found[n] = make_block(e, up, lf, rt, p, c, r - 1, 1'b0);
         n++;
      end
      older_line[c]  = recent_line[c];
      recent_line[c] = p;
      // bottom row flushes its own centers
      if (at_bottom) begin
         if (c >= 1) begin
            e  = prev_one;
            up = older_line[c - 1];
            lf = (c == 1) ? e : prev_two;
            found[n] = make_block(e, up, lf, p, e, c - 1, r, 1'b0);
            n++;
         end
         if (at_right) begin
            up = older_line[c];
            lf = (c == 0) ? p : prev_one;
            found[n] = make_block(p, up, lf, p, p, c, r, 1'b1);
            n++;
         end
      end
      if (n > 0) found[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) blocks_due.push_back(found[i]);
      // position update
      if (at_right) begin
         prev_one = '0;
         prev_two = '0;
         col_pos  = 0;
         row_pos  = at_bottom ? 0 : r + 1;
      end else begin
         prev_two = prev_one;
         prev_one = p;
         col_pos  = c + 1;
         row_pos  = r;
      end
   endfunction

   function automatic string block_str(input upscale_block_type b);
      return $sformatf("tl=%h tr=%h bl=%h br=%h col=%0d row=%0d end=%b last=%b",
                       b.top_left, b.top_right, b.bottom_left, b.bottom_right,
                       b.center_col, b.center_row, b.frame_end, b.last);
   endfunction

   // Output side: random stalls, compare each accepted block in order
   initial begin : block_checker
      upscale_block_type got;
      upscale_block_type want;
      int                hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = '{rsp_top_left, rsp_top_right, rsp_bottom_left, rsp_bottom_right,
                    rsp_center_col, rsp_center_row, rsp_frame_end, rsp_last};
            if (blocks_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected block: %s", block_str(got));
            end else begin
               want = blocks_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("block mismatch\n  expected %s\n  actual   %s",
                              block_str(want), block_str(got));
               end
            end
            hold = pause_len(sink_steady);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one pixel item after a random gap
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      gap = pause_len(src_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_stall);
      expand_pixel(pix);
   endtask

   // Wait until every predicted block is out and the pipeline is empty
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (blocks_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [SIZE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FRAME_WIDTH) cfg_width = val;
      else cfg_height = val;
   endtask

   task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   // Pixels from a small palette so neighbors often match; some fully random
   task automatic send_noise_frame(input int cols, input int rows);
      logic [PIX_W-1:0] palette [3];
      for (int i = 0; i < 3; i++) palette[i] = $urandom;
      for (int i = 0; i < cols * rows; i++) begin
         if ($urandom_range(0, 7) == 0) send_pixel($urandom);
         else send_pixel(palette[$urandom_range(0, 2)]);
      end
   endtask

   // Sizes below the minimum act as 2 x 2
   task automatic test_tiny_frame();
      drain_pipeline();
      set_frame(SIZE_W'(0), SIZE_W'(1));
      send_pixel(PIX_ZERO);
      send_pixel(PIX_ONES);
      send_pixel(PIX_ODD);
      send_pixel(PIX_EVEN);
   endtask

   // 3 x 3 frame whose center fires the Scale2x rule; edges use replaced neighbors
   task automatic test_rule_cases();
      logic [PIX_W-1:0] grid [9];
      grid = '{PIX_EVEN, PIX_ZERO, PIX_EVEN,
               PIX_ZERO, PIX_ODD,  PIX_ONES,
               PIX_EVEN, PIX_ONES, PIX_EVEN};
      drain_pipeline();
      set_frame(SIZE_W'(3), SIZE_W'(3));
      for (int i = 0; i < 9; i++) send_pixel(grid[i]);
   endtask

   // Shrink width, then height, while the position lies beyond the new size
   task automatic test_midframe_resize();
      drain_pipeline();
      set_frame(SIZE_W'(4), SIZE_W'(5));
      send_noise_frame(4, 2);
      send_pixel($urandom);
      send_pixel($urandom);
      drain_pipeline();
      set_frame(SIZE_W'(2), SIZE_W'(5));
      send_pixel($urandom);
      drain_pipeline();
      set_frame(SIZE_W'(2), SIZE_W'(3));
      send_pixel($urandom);
      send_pixel($urandom);
   endtask

   // Random small frames with random idle modes
   task automatic test_random_frames();
      int sent;
      int cols;
      int rows;
      sent = 0;
      while (sent < 24) begin
         cols = $urandom_range(2, 12);
         rows = $urandom_range(2, 6);
         drain_pipeline();
         set_frame(SIZE_W'(cols), SIZE_W'(rows));
         src_steady  = ($urandom_range(0, 3) == 0);
         sink_steady = ($urandom_range(0, 3) == 0);
         send_noise_frame(cols, rows);
         sent += cols * rows;
      end
      src_steady  = 1'b0;
      sink_steady = 1'b0;
   endtask

   // Widest row with sizes above the maximum; the frame then closes on a
   // second row sent at width 2 so it stays short
   task automatic test_largest_frames();
      drain_pipeline();
      set_frame(SIZE_W'(300), SIZE_W'(511));
      src_steady = 1'b1;
      send_noise_frame(MAX_WIDTH, 1);
      src_steady = 1'b0;
      drain_pipeline();
      set_frame(SIZE_W'(2), SIZE_W'(2));
      send_noise_frame(2, 1);
   endtask

   initial begin : run_tests
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tiny_frame();
      test_rule_cases();
      test_midframe_resize();
      test_random_frames();
      test_largest_frames();
      drain_pipeline();
      if (mismatches == 0 && blocks_due.size() == 0) begin
         $display("tb_scale2x_pixel_upscaler passed");
      end else begin
         $display("tb_scale2x_pixel_upscaler failed");
      end
      $finish;
   end

endmodule
